### rtl/dhpc_pkg.sv
// ----------------------------------------------------------------------------
// dhpc_pkg
// Shared types and constants for the DNS/HTTP packet classifier: Ethernet
// and IP codes, per-frame parse state and the HTTP method matcher.
// ----------------------------------------------------------------------------
package dhpc_pkg;

  localparam int POS_W = 17;

  localparam logic [15:0] ET_IPV4 = 16'h0800;
  localparam logic [15:0] ET_IPV6 = 16'h86DD;
  localparam logic [15:0] ET_VLAN = 16'h8100;
  localparam logic [15:0] ET_QINQ = 16'h88A8;

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  localparam logic [15:0] DNS_PORT_RESET = 16'd53;
  localparam logic [13:0] FRAG_CLEAR     = 14'h0000;

  // Smallest frame that can be kept: Ethernet, minimal IPv4, UDP header.
  localparam logic [15:0] MIN_KEEP_LEN = 16'd42;

  localparam logic [31:0] M_GET     = "GET ";
  localparam logic [39:0] M_POST    = "POST ";
  localparam logic [31:0] M_PUT     = "PUT ";
  localparam logic [47:0] M_PATCH   = "PATCH ";
  localparam logic [55:0] M_DELETE  = "DELETE ";
  localparam logic [39:0] M_HEAD    = "HEAD ";
  localparam logic [63:0] M_OPTIONS = "OPTIONS ";
  localparam logic [63:0] M_CONNECT = "CONNECT ";
  localparam logic [47:0] M_TRACE   = "TRACE ";

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [15:0]      etype;
    logic [4:0]       net_start;
    logic [3:0]       hdr_words;
    logic [15:0]      frag;
    logic [15:0]      ip_len;
    logic [7:0]       proto;
    logic [5:0]       tcp_hdr_bytes;
    logic [15:0]      dst_port;
  } frame_state_t;

  localparam frame_state_t FRAME_CLEAR = '{
    pos:           '0,
    etype:         '0,
    net_start:     5'd14,
    hdr_words:     '0,
    frag:          '0,
    ip_len:        '0,
    proto:         '0,
    tcp_hdr_bytes: '0,
    dst_port:      '0
  };

  function automatic logic is_tag(input logic [15:0] et);
    return (et == ET_VLAN) || (et == ET_QINQ);
  endfunction

  // head holds the first eight payload bytes, first byte in the top lane.
  function automatic logic http_method_match(input logic [63:0] head);
    return (head[63:32] == M_GET)    || (head[63:24] == M_POST)  ||
           (head[63:32] == M_PUT)    || (head[63:16] == M_PATCH) ||
           (head[63:8]  == M_DELETE) || (head[63:24] == M_HEAD)  ||
           (head == M_OPTIONS)       || (head == M_CONNECT)      ||
           (head[63:16] == M_TRACE);
  endfunction

endpackage

### rtl/dhpc_if.sv
// ----------------------------------------------------------------------------
// dhpc_if
// Valid/ready channels of the classifier: frame bytes in, verdicts out.
// ----------------------------------------------------------------------------
interface dhpc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, output data_byte, output last, input ready);
  modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface dhpc_out_if;
  logic        valid;
  logic        ready;
  logic        keep;
  logic [15:0] verdict_length;

  modport source (output valid, output keep, output verdict_length, input ready);
  modport sink   (input valid, input keep, input verdict_length, output ready);
endinterface

### rtl/dns_http_packet_classifier_core.sv
// ----------------------------------------------------------------------------
// dns_http_packet_classifier_core
// Parses Ethernet/VLAN/IPv4/IPv6/UDP/TCP headers one byte per item and
// gives a keep verdict for each frame, with the frame length if it is kept.
// ----------------------------------------------------------------------------
// Throughput: one frame byte per clock while in_if.ready is high.
// After the last byte is accepted, the frame state goes to the snapshot
//   stage and then to the verdict register.
// in_if.ready drops only while a verdict waits in the output register and
//   another one waits behind it in the snapshot stage.
// Reset (rst_n, synchronous, active low) clears parse state and the valid
//   flags of both stages and sets dns_port to 53.
module dns_http_packet_classifier_core
  import dhpc_pkg::*;
#(
  parameter int PREFIX_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  dhpc_in_if.sink     in_if,
  dhpc_out_if.source  out_if,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  localparam int IDX_W = $clog2(PREFIX_BYTES);
  localparam logic [POS_W-1:0] POS_MAX = '1;

  logic [15:0]   dns_port_r;
  frame_state_t  fs_r, fs_nxt, upd;
  frame_state_t  snap_r;
  logic          snap_v_r, out_v_r;
  logic          keep_r, keep_nxt;
  logic [15:0]   len_r;
  logic [7:0]    prefix_r      [PREFIX_BYTES];
  logic [7:0]    prefix_nxt    [PREFIX_BYTES];
  logic [7:0]    snap_prefix_r [PREFIX_BYTES];

  logic             in_fire, out_free, snap_adv;
  logic [7:0]       b;
  logic [POS_W-1:0] p, ns_pos, r_off, l4_pos, q_off, po_pos, pf_off;
  logic [6:0]       l4;
  logic [7:0]       po;
  logic             is_ip, pf_we;

  // --------------------------------------------------------------------------
  // Handshake
  // --------------------------------------------------------------------------
  assign in_fire  = in_if.valid && in_if.ready;
  assign out_free = !out_v_r || out_if.ready;
  assign snap_adv = snap_v_r && out_free;
  assign in_if.ready = !snap_v_r || out_free;

  // --------------------------------------------------------------------------
  // Per-byte header parse
  // --------------------------------------------------------------------------
  assign b      = in_if.data_byte;
  assign p      = fs_r.pos;
  assign ns_pos = POS_W'(fs_r.net_start);
  assign r_off  = p - ns_pos;

  // Transport start from settled header fields; it lies past every byte
  // that could still change them.
  assign is_ip  = (fs_r.etype == ET_IPV4) || (fs_r.etype == ET_IPV6);
  assign l4     = (fs_r.etype == ET_IPV4) ?
                  7'(fs_r.net_start) + 7'({fs_r.hdr_words, 2'b00}) :
                  7'(fs_r.net_start) + 7'd40;
  assign l4_pos = POS_W'(l4);
  assign q_off  = p - l4_pos;
  assign po     = 8'(l4) + 8'(fs_r.tcp_hdr_bytes);
  assign po_pos = POS_W'(po);
  assign pf_off = p - po_pos;
  assign pf_we  = in_fire && is_ip && (p >= po_pos) && (pf_off < POS_W'(PREFIX_BYTES));

  always_comb begin
    upd = fs_r;

    if (p == POS_W'(12)) begin
      upd.etype[15:8] = b;
    end
    if (p == POS_W'(13)) begin
      upd.etype[7:0] = b;
      if (is_tag({fs_r.etype[15:8], b})) begin
        upd.net_start = 5'd18;
      end
    end
    if (fs_r.net_start == 5'd18 && p == POS_W'(16)) begin
      upd.etype[15:8] = b;
    end
    if (fs_r.net_start == 5'd18 && p == POS_W'(17)) begin
      upd.etype[7:0] = b;
      if (is_tag({fs_r.etype[15:8], b})) begin
        upd.net_start = 5'd22;
      end
    end
    if (fs_r.net_start == 5'd22 && p == POS_W'(20)) begin
      upd.etype[15:8] = b;
    end
    if (fs_r.net_start == 5'd22 && p == POS_W'(21)) begin
      upd.etype[7:0] = b;
    end

    if (p >= ns_pos) begin
      if (fs_r.etype == ET_IPV4) begin
        if (r_off == POS_W'(0)) upd.hdr_words    = b[3:0];
        if (r_off == POS_W'(2)) upd.ip_len[15:8] = b;
        if (r_off == POS_W'(3)) upd.ip_len[7:0]  = b;
        if (r_off == POS_W'(6)) upd.frag[15:8]   = b;
        if (r_off == POS_W'(7)) upd.frag[7:0]    = b;
        if (r_off == POS_W'(9)) upd.proto        = b;
      end else if (fs_r.etype == ET_IPV6) begin
        if (r_off == POS_W'(4)) upd.ip_len[15:8] = b;
        if (r_off == POS_W'(5)) upd.ip_len[7:0]  = b;
        if (r_off == POS_W'(6)) upd.proto        = b;
      end
    end

    if (is_ip && p >= l4_pos) begin
      if (q_off == POS_W'(2))  upd.dst_port[15:8]  = b;
      if (q_off == POS_W'(3))  upd.dst_port[7:0]   = b;
      if (q_off == POS_W'(12)) upd.tcp_hdr_bytes   = {b[7:4], 2'b00};
    end

    // Saturate the byte count.
    upd.pos = (p == POS_MAX) ? p : p + POS_W'(1);
  end

  always_comb begin
    fs_nxt = fs_r;
    if (in_fire) begin
      fs_nxt = in_if.last ? FRAME_CLEAR : upd;
    end
  end

  always_comb begin
    for (int i = 0; i < PREFIX_BYTES; i++) begin
      prefix_nxt[i] = (pf_we && pf_off[IDX_W-1:0] == IDX_W'(i)) ? b : prefix_r[i];
    end
  end

  // --------------------------------------------------------------------------
  // Verdict from the snapshot of a finished frame
  // --------------------------------------------------------------------------
  logic [POS_W-1:0] v_len, v_ns, v_l4, v_pe, v_po, v_ip_len;
  logic [5:0]       v_ihl;
  logic             v_len_ok, v_net_ok, v_udp_ok, v_tcp_ok;
  logic [63:0]      v_head;

  always_comb begin
    v_len    = snap_r.pos;
    v_ns     = POS_W'(snap_r.net_start);
    v_ihl    = {snap_r.hdr_words, 2'b00};
    v_ip_len = POS_W'(snap_r.ip_len);
    v_len_ok = !v_len[POS_W-1] && (v_len >= POS_W'(14));
    v_net_ok = 1'b0;
    v_l4     = '0;
    v_pe     = '0;

    if (snap_r.etype == ET_IPV4) begin
      v_l4     = v_ns + POS_W'(v_ihl);
      v_pe     = v_ns + v_ip_len;
      v_net_ok = (v_len >= v_ns + POS_W'(20)) && (snap_r.hdr_words >= 4'd5) &&
                 (snap_r.frag[13:0] == FRAG_CLEAR) && (v_pe <= v_len) &&
                 (v_pe >= v_l4);
    end else if (snap_r.etype == ET_IPV6) begin
      v_l4     = v_ns + POS_W'(40);
      v_pe     = v_l4 + v_ip_len;
      v_net_ok = (v_len >= v_l4) && (v_pe <= v_len);
    end

    v_po     = v_l4 + POS_W'(snap_r.tcp_hdr_bytes);
    v_udp_ok = (v_pe >= v_l4 + POS_W'(8)) && (snap_r.dst_port == dns_port_r);

    for (int i = 0; i < 8; i++) begin
      v_head[63 - 8*i -: 8] = snap_prefix_r[i];
    end

    v_tcp_ok = (v_pe >= v_l4 + POS_W'(20)) && (snap_r.tcp_hdr_bytes >= 6'd20) &&
               (v_pe >= v_po + POS_W'(PREFIX_BYTES)) && http_method_match(v_head);

    keep_nxt = v_len_ok && v_net_ok &&
               (((snap_r.proto == PROTO_UDP) && v_udp_ok) ||
                ((snap_r.proto == PROTO_TCP) && v_tcp_ok));
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fs_r       <= FRAME_CLEAR;
      dns_port_r <= DNS_PORT_RESET;
      snap_v_r   <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      fs_r <= fs_nxt;
      if (cfg_we) begin
        dns_port_r <= cfg_wdata;
      end
      if (in_fire && in_if.last) begin
        snap_v_r <= 1'b1;
      end else if (snap_adv) begin
        snap_v_r <= 1'b0;
      end
      if (snap_adv) begin
        out_v_r <= 1'b1;
      end else if (out_if.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pf_we) begin
      prefix_r[pf_off[IDX_W-1:0]] <= b;
    end
    if (in_fire && in_if.last) begin
      snap_r <= upd;
      for (int i = 0; i < PREFIX_BYTES; i++) begin
        snap_prefix_r[i] <= prefix_nxt[i];
      end
    end
    if (snap_adv) begin
      keep_r <= keep_nxt;
      len_r  <= keep_nxt ? v_len[15:0] : 16'd0;
    end
  end

  assign out_if.valid          = out_v_r;
  assign out_if.keep           = keep_r;
  assign out_if.verdict_length = len_r;

endmodule

### rtl/dhpc_checker.sv
// ----------------------------------------------------------------------------
// dhpc_checker
// Port-level checks on the classifier: held verdicts, verdict consistency
// and the cause of input backpressure.
// ----------------------------------------------------------------------------
module dhpc_checker
  import dhpc_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_keep,
  input logic [15:0] out_len
);

  // Hold a stalled verdict.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_keep) && $stable(out_len))
    else $error("verdict changed while stalled");

  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_keep |-> out_len == 16'd0)
    else $error("dropped frame with nonzero length");

  a_keep_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_keep |-> out_len >= MIN_KEEP_LEN)
    else $error("kept frame shorter than minimal headers");

  // Backpressure only while a verdict is stuck at the output.
  a_bp_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");

endmodule

bind dns_http_packet_classifier_core dhpc_checker u_dhpc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_keep  (out_if.keep),
  .out_len   (out_if.verdict_length)
);
